// ----- rtl/pidl_pkg.sv -----
// Shared types, constants and word conversion helpers for the positional list.
package pidl_pkg;

  localparam int CAPACITY  = 32;
  localparam int WORD_BITS = 32;

  // Fixed field widths of the request and response channels
  localparam int ACTION_W = 2;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 5;
  localparam int LEN_W    = 6;

  // Internal widths derived from the capacity
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_TRAVERSE = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OUT_OK    = 2'd0,
    OUT_FULL  = 2'd1,
    OUT_RANGE = 2'd2,
    OUT_EMPTY = 2'd3
  } outcome_t;

  typedef enum logic {
    ST_IDLE,
    ST_TRAV
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     do_insert;
    logic     do_delete;
    logic     load_res;
    logic     res_data;
    logic     res_idx;
    logic     res_last;
    outcome_t res_outcome;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_sel_idx;
  } pidl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic ins_range;
    logic empty;
    logic del_range;
    logic trav_last;
  } pidl_sts_t;

  // Stored word to 32-bit output, sign-extended from the stored width
  function automatic logic [DATA_W-1:0] word_to_data(logic [WORD_BITS-1:0] w);
    logic [63:0] ext;
    ext = 64'(signed'(w));
    return ext[DATA_W-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] data_to_word(logic [DATA_W-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[WORD_BITS-1:0];
  endfunction

endpackage

// ----- rtl/pidl_in_if.sv -----
// Request channel: action, position and value with valid/ready.
interface pidl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [pidl_pkg::ACTION_W-1:0]         action;
  logic [pidl_pkg::POS_W-1:0]            position;
  logic signed [pidl_pkg::DATA_W-1:0]    value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

// ----- rtl/pidl_out_if.sv -----
// Response channel: one result item per transfer with valid/ready.
interface pidl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pidl_pkg::DATA_W-1:0]    data_word;
  logic [pidl_pkg::ENTRY_W-1:0]          entry_index;
  logic [pidl_pkg::LEN_W-1:0]            length_now;
  logic                                  last_of_run;
  logic [1:0]                            outcome;

  modport source (output valid, data_word, entry_index, length_now, last_of_run, outcome,
                  input ready);
  modport sink   (input valid, data_word, entry_index, length_now, last_of_run, outcome,
                  output ready);
endinterface

// ----- rtl/positional_insert_delete_list_core.sv -----
// Top level of the positional insert/delete list.
//
//   channel  dir  payload                                              transfer
//   req      in   action, position, value                              valid & ready
//   rsp      out  data_word, entry_index, length_now, last_of_run,     valid & ready
//                 outcome
//
// Insert and delete shift the cells at and above the position in parallel; these and
// failed requests put their result in a single output register. A traverse clears
// its index, then reads one held entry per result through the one read port on the
// cells, holding while rsp is stalled. One request is in work at a time. A waiting
// response stalls the next request only when the output register is full and rsp.ready
// is low. Synchronous reset empties the list; cell contents are not reset.
module positional_insert_delete_list_core (
  input logic        clk,
  input logic        rst,
  pidl_in_if.sink    req,
  pidl_out_if.source rsp
);

  pidl_pkg::pidl_cmd_t cmd;
  pidl_pkg::pidl_sts_t sts;

  pidl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pidl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .position    (req.position),
    .value       (req.value),
    .cmd         (cmd),
    .sts         (sts),
    .data_word   (rsp.data_word),
    .entry_index (rsp.entry_index),
    .length_now  (rsp.length_now),
    .last_of_run (rsp.last_of_run),
    .outcome     (rsp.outcome)
  );

endmodule

// ----- rtl/pidl_ctrl.sv -----
// Controller: request decode, traverse sequencing and response valid.
module pidl_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic [pidl_pkg::ACTION_W-1:0]  req_action,
  output logic                           req_ready,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  input  pidl_pkg::pidl_sts_t            sts,
  output pidl_pkg::pidl_cmd_t            cmd
);

  pidl_pkg::state_t state, state_next;
  logic             out_valid, out_valid_next;
  logic             can_load;
  logic             accept;
  pidl_pkg::action_t act;

  assign act       = pidl_pkg::action_t'(req_action);
  assign can_load  = !out_valid || rsp_ready;
  assign req_ready = (state == pidl_pkg::ST_IDLE) && can_load;
  assign accept    = req_valid && req_ready;
  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pidl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.res_outcome = pidl_pkg::OUT_OK;
    unique case (state)
      pidl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (act)
            pidl_pkg::ACT_INSERT: begin
              cmd.load_res = 1'b1;
              cmd.res_last = 1'b1;
              if (sts.full)
                cmd.res_outcome = pidl_pkg::OUT_FULL;
              else if (sts.ins_range)
                cmd.res_outcome = pidl_pkg::OUT_RANGE;
              else
                cmd.do_insert = 1'b1;
            end
            pidl_pkg::ACT_DELETE: begin
              cmd.load_res = 1'b1;
              cmd.res_last = 1'b1;
              if (sts.empty)
                cmd.res_outcome = pidl_pkg::OUT_EMPTY;
              else if (sts.del_range)
                cmd.res_outcome = pidl_pkg::OUT_RANGE;
              else begin
                cmd.do_delete = 1'b1;
                cmd.res_data  = 1'b1;
              end
            end
            pidl_pkg::ACT_TRAVERSE: begin
              if (sts.empty) begin
                cmd.load_res    = 1'b1;
                cmd.res_last    = 1'b1;
                cmd.res_outcome = pidl_pkg::OUT_EMPTY;
              end else begin
                cmd.idx_clr = 1'b1;
                state_next  = pidl_pkg::ST_TRAV;
              end
            end
            default: ;
          endcase
        end
      end
      pidl_pkg::ST_TRAV: begin
        cmd.rd_sel_idx = 1'b1;
        if (can_load) begin
          cmd.load_res = 1'b1;
          cmd.res_data = 1'b1;
          cmd.res_idx  = 1'b1;
          cmd.res_last = sts.trav_last;
          if (sts.trav_last)
            state_next = pidl_pkg::ST_IDLE;
          else
            cmd.idx_inc = 1'b1;
        end
      end
      default: state_next = pidl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_res)
      out_valid_next = 1'b1;
    else if (rsp_ready)
      out_valid_next = 1'b0;
    else
      out_valid_next = out_valid;
  end

endmodule

// ----- rtl/pidl_dp.sv -----
// Datapath: shifting entry cells, held count, traverse index and result register.
module pidl_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pidl_pkg::POS_W-1:0]        position,
  input  logic [pidl_pkg::DATA_W-1:0]       value,
  input  pidl_pkg::pidl_cmd_t               cmd,
  output pidl_pkg::pidl_sts_t               sts,
  output logic [pidl_pkg::DATA_W-1:0]       data_word,
  output logic [pidl_pkg::ENTRY_W-1:0]      entry_index,
  output logic [pidl_pkg::LEN_W-1:0]        length_now,
  output logic                              last_of_run,
  output logic [1:0]                        outcome
);

  logic [pidl_pkg::WORD_BITS-1:0] cells [pidl_pkg::CAPACITY];
  logic [pidl_pkg::CNT_W-1:0]     count, count_next;
  logic [pidl_pkg::IDX_W-1:0]     idx;
  logic [pidl_pkg::IDX_W-1:0]     rd_addr;
  logic [pidl_pkg::WORD_BITS-1:0] rd_word;
  logic [pidl_pkg::WORD_BITS-1:0] in_word;
  logic [pidl_pkg::CMP_W-1:0]     pos_x, count_x;

  assign pos_x   = pidl_pkg::CMP_W'(position);
  assign count_x = pidl_pkg::CMP_W'(count);
  assign in_word = pidl_pkg::data_to_word(value);

  assign sts.full      = (count == pidl_pkg::CNT_W'(pidl_pkg::CAPACITY));
  assign sts.ins_range = (pos_x > count_x);
  assign sts.empty     = (count == '0);
  assign sts.del_range = (pos_x >= count_x);
  assign sts.trav_last = ((pidl_pkg::CNT_W'(idx) + pidl_pkg::CNT_W'(1)) == count);

  assign rd_addr = cmd.rd_sel_idx ? idx : position[pidl_pkg::IDX_W-1:0];
  assign rd_word = cells[rd_addr];

  always_comb begin
    count_next = count;
    if (cmd.do_insert)
      count_next = count + pidl_pkg::CNT_W'(1);
    else if (cmd.do_delete)
      count_next = count - pidl_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Cells at and above the position shift at once: up on insert, down on delete
  for (genvar gi = 0; gi < pidl_pkg::CAPACITY; gi++) begin : g_cell
    localparam int PREV = (gi == 0) ? 0 : gi - 1;
    localparam int NXT  = (gi == pidl_pkg::CAPACITY - 1) ? gi : gi + 1;
    logic [pidl_pkg::CMP_W-1:0] here;
    assign here = pidl_pkg::CMP_W'(gi);

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (here == pos_x)
          cells[gi] <= in_word;
        else if (here > pos_x)
          cells[gi] <= cells[PREV];
      end else if (cmd.do_delete) begin
        if (here >= pos_x)
          cells[gi] <= cells[NXT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr)
      idx <= '0;
    else if (cmd.idx_inc)
      idx <= idx + pidl_pkg::IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      data_word   <= cmd.res_data ? pidl_pkg::word_to_data(rd_word) : '0;
      entry_index <= cmd.res_idx ? pidl_pkg::ENTRY_W'(idx) : '0;
      length_now  <= pidl_pkg::LEN_W'(count_next);
      last_of_run <= cmd.res_last;
      outcome     <= cmd.res_outcome;
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for the positional insert/delete list: random requests, shadow list.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pidl_pkg::action_t                 act;
    logic [pidl_pkg::POS_W-1:0]        pos;
    logic [pidl_pkg::DATA_W-1:0]       val;
  } list_req_t;

  typedef struct packed {
    logic [pidl_pkg::DATA_W-1:0]  data_word;
    logic [pidl_pkg::ENTRY_W-1:0] entry_index;
    logic [pidl_pkg::LEN_W-1:0]   length_now;
    logic                         last_of_run;
    pidl_pkg::outcome_t           outcome;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst;

  pidl_in_if  req ();
  pidl_out_if rsp ();

  positional_insert_delete_list_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  list_req_t                   pending_reqs [$];
  list_rsp_t                   awaited_results [$];
  list_req_t                   in_flight;
  logic [pidl_pkg::DATA_W-1:0] shadow_cells [pidl_pkg::CAPACITY];
  int                          shadow_len;
  int                          gen_len;
  int                          mismatches;
  int                          cycle_cnt;
  logic                        idle_on;

  always #5 clk = ~clk;

  // Updates the shadow list for one accepted request and queues its results.
  function automatic void apply_list_op(list_req_t r);
    list_rsp_t res;
    int        p;
    p = int'(r.pos);
    res = '{data_word: '0, entry_index: '0, length_now: '0, last_of_run: 1'b1,
            outcome: pidl_pkg::OUT_OK};
    case (r.act)
      pidl_pkg::ACT_INSERT: begin
        if (shadow_len >= pidl_pkg::CAPACITY) begin
          res.outcome = pidl_pkg::OUT_FULL;
        end else if (p > shadow_len) begin
          res.outcome = pidl_pkg::OUT_RANGE;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[p] = r.val;
          shadow_len++;
        end
        res.length_now = pidl_pkg::LEN_W'(shadow_len);
        awaited_results.push_back(res);
      end
      pidl_pkg::ACT_DELETE: begin
        if (shadow_len == 0) begin
          res.outcome = pidl_pkg::OUT_EMPTY;
        end else if (p >= shadow_len) begin
          res.outcome = pidl_pkg::OUT_RANGE;
        end else begin
          res.data_word = shadow_cells[p];
          for (int i = p + 1; i < shadow_len; i++) shadow_cells[i-1] = shadow_cells[i];
          shadow_len--;
        end
        res.length_now = pidl_pkg::LEN_W'(shadow_len);
        awaited_results.push_back(res);
      end
      pidl_pkg::ACT_TRAVERSE: begin
        if (shadow_len == 0) begin
          res.outcome = pidl_pkg::OUT_EMPTY;
          awaited_results.push_back(res);
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            res.data_word   = shadow_cells[i];
            res.entry_index = pidl_pkg::ENTRY_W'(i);
            res.length_now  = pidl_pkg::LEN_W'(shadow_len);
            res.last_of_run = (i + 1 == shadow_len);
            awaited_results.push_back(res);
          end
        end
      end
      default: ;  // unused code: no result, no change
    endcase
  endfunction

  // Queues a request and tracks the list length the generator expects.
  task automatic queue_req(pidl_pkg::action_t act, int pos,
                           logic [pidl_pkg::DATA_W-1:0] val);
    list_req_t r;
    r.act = act;
    r.pos = pidl_pkg::POS_W'(pos);
    r.val = val;
    pending_reqs.push_back(r);
    if (act == pidl_pkg::ACT_INSERT && gen_len < pidl_pkg::CAPACITY && pos <= gen_len)
      gen_len++;
    if (act == pidl_pkg::ACT_DELETE && gen_len > 0 && pos < gen_len) gen_len--;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) apply_list_op(in_flight);
      if (!req.valid || req.ready) begin
        if (pending_reqs.size() > 0 && !(idle_on && $urandom_range(0, 99) < 10)) begin
          in_flight = pending_reqs.pop_front();
          req.valid    <= 1'b1;
          req.action   <= in_flight.act;
          req.position <= in_flight.pos;
          req.value    <= in_flight.val;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and backpressure
  always @(posedge clk) begin
    list_rsp_t exp_rsp;
    if (rst) begin
      rsp.ready <= 1'b0;
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      rsp.ready <= !(idle_on && $urandom_range(0, 99) < 10);
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected response data_word=%0h entry_index=%0d length_now=%0d",
                   $time, rsp.data_word, rsp.entry_index, rsp.length_now);
          mismatches++;
        end else begin
          exp_rsp = awaited_results.pop_front();
          if (rsp.data_word !== exp_rsp.data_word) begin
            $display("%0t: data_word expected %0h actual %0h", $time,
                     exp_rsp.data_word, rsp.data_word);
            mismatches++;
          end
          if (rsp.entry_index !== exp_rsp.entry_index) begin
            $display("%0t: entry_index expected %0d actual %0d", $time,
                     exp_rsp.entry_index, rsp.entry_index);
            mismatches++;
          end
          if (rsp.length_now !== exp_rsp.length_now) begin
            $display("%0t: length_now expected %0d actual %0d", $time,
                     exp_rsp.length_now, rsp.length_now);
            mismatches++;
          end
          if (rsp.last_of_run !== exp_rsp.last_of_run) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time,
                     exp_rsp.last_of_run, rsp.last_of_run);
            mismatches++;
          end
          if (rsp.outcome !== exp_rsp.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time,
                     exp_rsp.outcome, rsp.outcome);
            mismatches++;
          end
        end
      end
    end
  end

  // No idling on either side inside this window
  always_comb idle_on = !(cycle_cnt >= 400 && cycle_cnt < 900);

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int  r;
    int  req_cnt;
    logic filling;
    rst = 1'b1;

    // directed: empty list, edges of the value range, front/middle/end moves
    queue_req(pidl_pkg::ACT_TRAVERSE, 0, '0);
    queue_req(pidl_pkg::ACT_DELETE, 0, '0);
    queue_req(pidl_pkg::ACT_DELETE, 63, '0);
    queue_req(pidl_pkg::ACT_INSERT, 1, 32'h1111_1111);
    queue_req(pidl_pkg::ACT_INSERT, 0, 32'h7FFF_FFFF);
    queue_req(pidl_pkg::ACT_INSERT, 0, 32'h8000_0000);
    queue_req(pidl_pkg::ACT_INSERT, 2, 32'hFFFF_FFFF);
    queue_req(pidl_pkg::ACT_INSERT, 1, 32'h0000_0000);
    queue_req(pidl_pkg::ACT_INSERT, 63, 32'hDEAD_BEEF);
    queue_req(pidl_pkg::ACT_NOP, 5, 32'h1234_5678);
    queue_req(pidl_pkg::ACT_TRAVERSE, 0, '0);
    queue_req(pidl_pkg::ACT_DELETE, 4, '0);
    queue_req(pidl_pkg::ACT_DELETE, 63, '0);
    queue_req(pidl_pkg::ACT_DELETE, 1, '0);
    queue_req(pidl_pkg::ACT_DELETE, 2, '0);
    queue_req(pidl_pkg::ACT_DELETE, 0, '0);
    queue_req(pidl_pkg::ACT_TRAVERSE, 0, '0);
    queue_req(pidl_pkg::ACT_DELETE, 0, '0);
    queue_req(pidl_pkg::ACT_TRAVERSE, 0, '0);

    // random: alternate fill and drain phases so the full list gets reached
    filling = 1'b1;
    req_cnt = 0;
    while (req_cnt < 390) begin
      r = $urandom_range(0, 99);
      if (filling && gen_len == pidl_pkg::CAPACITY) begin
        queue_req(pidl_pkg::ACT_TRAVERSE, 0, '0);
        queue_req(pidl_pkg::ACT_INSERT, $urandom_range(0, 63), $urandom);
        req_cnt += 2;
        filling = 1'b0;
      end else if (!filling && gen_len == 0) begin
        queue_req(pidl_pkg::ACT_DELETE, $urandom_range(0, 63), '0);
        req_cnt++;
        filling = 1'b1;
      end else if (r < 70) begin
        if (filling)
          queue_req(pidl_pkg::ACT_INSERT, $urandom_range(0, gen_len), $urandom);
        else queue_req(pidl_pkg::ACT_DELETE, $urandom_range(0, gen_len - 1), $urandom);
        req_cnt++;
      end else if (r < 78) begin
        if (filling && gen_len > 0)
          queue_req(pidl_pkg::ACT_DELETE, $urandom_range(0, gen_len - 1), $urandom);
        else if (filling) queue_req(pidl_pkg::ACT_DELETE, $urandom_range(0, 63), $urandom);
        else queue_req(pidl_pkg::ACT_INSERT, $urandom_range(0, gen_len), $urandom);
        req_cnt++;
      end else if (r < 86) begin
        queue_req(pidl_pkg::ACT_TRAVERSE, $urandom_range(0, 63), $urandom);
        req_cnt++;
      end else if (r < 93) begin
        queue_req(pidl_pkg::ACT_INSERT, $urandom_range(gen_len + 1, 63), $urandom);
        req_cnt++;
      end else if (r < 97) begin
        queue_req(pidl_pkg::ACT_DELETE, $urandom_range(gen_len, 63), $urandom);
        req_cnt++;
      end else begin
        queue_req(pidl_pkg::ACT_NOP, $urandom_range(0, 63), $urandom);
        req_cnt++;
      end
      if ($urandom_range(0, 99) < 3) filling = !filling;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() > 0 || req.valid || awaited_results.size() > 0);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
